/* src/xcpd_pkg.sv */
// shared types and constants for the xor checked packet deframer
// no dependencies; used by every module in src

package xcpd_pkg;

  localparam logic [7:0] START_BYTE = 8'h1B;
  localparam logic [7:0] TOKEN_BYTE = 8'h0E;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  // input request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_FRAMING = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEQ     = 3'd1,
    PH_SIZE_HI = 3'd2,
    PH_SIZE_LO = 3'd3,
    PH_TOKEN   = 3'd4,
    PH_DATA    = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    status_t     status;
    logic [7:0]  seq_number;
    logic [15:0] frame_size;
  } res_t;

endpackage

/* src/xcpd_core.sv */
// frame parser: phase machine, header registers, byte counter and running xor
// depends on xcpd_pkg

module xcpd_core #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             req_type,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output xcpd_pkg::res_t   res
);

  localparam logic [16:0] MaxPayloadW = 17'(MAX_PAYLOAD);

  xcpd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  b;
  logic [15:0] size_lo_val;
  logic [15:0] count_inc;
  logic        size_too_big;

  assign b            = rx_byte & xcpd_pkg::BYTE_MASK;
  assign size_lo_val  = {size_r[15:8], b};
  assign count_inc    = count_r + 16'd1;
  assign size_too_big = {1'b0, size_lo_val} >= MaxPayloadW;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (req_type == xcpd_pkg::REQ_TICK) begin
      phase_nxt = xcpd_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        xcpd_pkg::PH_IDLE: begin
          phase_nxt = (b == xcpd_pkg::START_BYTE) ? xcpd_pkg::PH_SEQ : xcpd_pkg::PH_IDLE;
        end
        xcpd_pkg::PH_SEQ:     phase_nxt = xcpd_pkg::PH_SIZE_HI;
        xcpd_pkg::PH_SIZE_HI: phase_nxt = xcpd_pkg::PH_SIZE_LO;
        xcpd_pkg::PH_SIZE_LO: begin
          phase_nxt = size_too_big ? xcpd_pkg::PH_IDLE : xcpd_pkg::PH_TOKEN;
        end
        xcpd_pkg::PH_TOKEN: begin
          if (b != xcpd_pkg::TOKEN_BYTE) begin
            phase_nxt = xcpd_pkg::PH_IDLE;
          end else if (size_r == 16'd0) begin
            phase_nxt = xcpd_pkg::PH_CHECK;
          end else begin
            phase_nxt = xcpd_pkg::PH_DATA;
          end
        end
        xcpd_pkg::PH_DATA: begin
          phase_nxt = (count_inc == size_r) ? xcpd_pkg::PH_CHECK : xcpd_pkg::PH_DATA;
        end
        xcpd_pkg::PH_CHECK: phase_nxt = xcpd_pkg::PH_IDLE;
        default:            phase_nxt = xcpd_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    seq_nxt          = seq_r;
    size_nxt         = size_r;
    count_nxt        = count_r;
    xor_nxt          = xor_r;
    res_valid        = 1'b0;
    res.kind         = xcpd_pkg::KIND_STATUS;
    res.payload_byte = 8'd0;
    res.byte_index   = count_r;
    res.status       = xcpd_pkg::ST_OK;
    res.seq_number   = seq_r;
    res.frame_size   = size_r;
    if (req_type == xcpd_pkg::REQ_TICK) begin
      if (phase_r != xcpd_pkg::PH_IDLE) begin
        res_valid  = 1'b1;
        res.status = xcpd_pkg::ST_TIMEOUT;
      end
    end else begin
      unique case (phase_r)
        xcpd_pkg::PH_IDLE: begin
          seq_nxt        = 8'd0;
          size_nxt       = 16'd0;
          count_nxt      = 16'd0;
          res.byte_index = 16'd0;
          res.seq_number = 8'd0;
          res.frame_size = 16'd0;
          if (b != xcpd_pkg::START_BYTE) begin
            res_valid  = 1'b1;
            res.status = xcpd_pkg::ST_FRAMING;
          end else begin
            xor_nxt = xcpd_pkg::START_BYTE;
          end
        end
        xcpd_pkg::PH_SEQ: begin
          seq_nxt = b;
          xor_nxt = xor_r ^ b;
        end
        xcpd_pkg::PH_SIZE_HI: begin
          size_nxt = {b, 8'd0};
          xor_nxt  = xor_r ^ b;
        end
        xcpd_pkg::PH_SIZE_LO: begin
          size_nxt       = size_lo_val;
          xor_nxt        = xor_r ^ b;
          count_nxt      = 16'd0;
          res.byte_index = 16'd0;
          res.frame_size = size_lo_val;
          if (size_too_big) begin
            res_valid  = 1'b1;
            res.status = xcpd_pkg::ST_FRAMING;
          end
        end
        xcpd_pkg::PH_TOKEN: begin
          if (b != xcpd_pkg::TOKEN_BYTE) begin
            res_valid  = 1'b1;
            res.status = xcpd_pkg::ST_FRAMING;
          end else begin
            xor_nxt = xor_r ^ b;
          end
        end
        xcpd_pkg::PH_DATA: begin
          res_valid        = 1'b1;
          res.kind         = xcpd_pkg::KIND_DATA;
          res.payload_byte = b;
          xor_nxt          = xor_r ^ b;
          count_nxt        = count_inc;
        end
        xcpd_pkg::PH_CHECK: begin
          res_valid  = 1'b1;
          res.status = (xor_r == b) ? xcpd_pkg::ST_OK : xcpd_pkg::ST_BAD_SUM;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xcpd_pkg::PH_IDLE;
      seq_r   <= 8'd0;
      size_r  <= 16'd0;
      count_r <= 16'd0;
      xor_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      size_r  <= size_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

/* src/xcpd_out_stage.sv */
// two-entry result stage: output register plus skid register
// depends on xcpd_pkg

module xcpd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xcpd_pkg::res_t push_data,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output xcpd_pkg::res_t out_data
);

  logic           main_valid_r;
  logic           skid_valid_r;
  xcpd_pkg::res_t main_r;
  xcpd_pkg::res_t skid_r;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !out_ready) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

endmodule

/* src/xor_checked_packet_deframer.sv */
// top level of the xor checked packet deframer
// depends on xcpd_pkg, xcpd_core and xcpd_out_stage

// Takes one transfer per clock: a serial byte or a packet timeout tick. Frames
// are start byte 0x1B, sequence number, 16-bit size high byte first, token 0x0E,
// the payload and an xor checksum over all earlier bytes. Each payload byte
// leaves as a data item with its index, and each frame ends in one status item
// (ok, bad checksum, framing error, timeout); header bytes and idle ticks give
// nothing. The parser updates its state in the cycle a transfer is taken and its
// result is registered before it reaches the out_ port. A two-entry output stage
// (register plus skid) keeps in_ready high while one result waits, so a new item
// is taken every cycle until two results are held; in_ready drops only then.

module xor_checked_packet_deframer #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_byte_index,
  output logic [1:0]  out_status,
  output logic [7:0]  out_seq_number,
  output logic [15:0] out_frame_size
);

  logic           in_xfer;    // input transfer this cycle
  logic           res_valid;
  xcpd_pkg::res_t res;
  xcpd_pkg::res_t out_data;
  logic           can_push;

  assign in_ready = can_push;
  assign in_xfer  = in_valid && in_ready;

  // parser state advances only on an accepted transfer
  xcpd_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_xfer),
    .req_type (in_req_type),
    .rx_byte  (in_rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  // result register with skid entry
  xcpd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer && res_valid),
    .push_data(res),
    .can_push (can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_byte_index   = out_data.byte_index;
  assign out_status       = out_data.status;
  assign out_seq_number   = out_data.seq_number;
  assign out_frame_size   = out_data.frame_size;

endmodule

/* verif/tb_top.sv */
// self-checking testbench for xor_checked_packet_deframer: a short directed frame list, then
// random frame traffic with sender bursts and receiver stalls; depends on xcpd_pkg and the rtl
// in src, and predicts the results of all untyped items in its own frame tracker

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD        = 512;
  localparam int RANDOM_ITEMS       = 1250;
  // no transfer on either side for this many cycles means the block hung
  localparam int WATCHDOG_LIMIT     = 2000;
  // the result is registered in a two-entry output stage before it leaves
  localparam int DRAIN_CYCLES       = 8;
  localparam int LONG_HOLD_CYCLES   = 80;
  localparam int HOLD_AFTER_RESULTS = 300;

  // receiver stall patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_TOGGLE
  } ready_mode_t;

  // one row of the directed list; want is used only where typed is set
  typedef struct {
    logic           req;
    logic [7:0]     data;
    bit             typed;
    xcpd_pkg::res_t want;
  } stim_row_t;

  // results that can be read straight off the frame format
  localparam xcpd_pkg::res_t NO_RESULT     = '0;
  localparam xcpd_pkg::res_t FRAMING_IDLE  = '{xcpd_pkg::KIND_STATUS, 8'h00, 16'h0000,
                                               xcpd_pkg::ST_FRAMING, 8'h00, 16'h0000};
  localparam xcpd_pkg::res_t FRAMING_BIG   = '{xcpd_pkg::KIND_STATUS, 8'h00, 16'h0000,
                                               xcpd_pkg::ST_FRAMING, 8'h00, 16'h0200};
  localparam xcpd_pkg::res_t FRAMING_TOKEN = '{xcpd_pkg::KIND_STATUS, 8'h00, 16'h0000,
                                               xcpd_pkg::ST_FRAMING, 8'hFF, 16'h0001};
  localparam xcpd_pkg::res_t DATA_FF       = '{xcpd_pkg::KIND_DATA, 8'hFF, 16'h0000,
                                               xcpd_pkg::ST_OK, 8'h80, 16'h0001};
  localparam xcpd_pkg::res_t TIMEOUT_SUM   = '{xcpd_pkg::KIND_STATUS, 8'h00, 16'h0001,
                                               xcpd_pkg::ST_TIMEOUT, 8'h80, 16'h0001};

  stim_row_t directed_rows [25] = '{
    // tick while idle is dropped
    '{xcpd_pkg::REQ_TICK, 8'h00, 1'b0, NO_RESULT},
    // wrong start byte, both extremes of the byte
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b1, FRAMING_IDLE},
    '{xcpd_pkg::REQ_BYTE, 8'hFF, 1'b1, FRAMING_IDLE},
    // empty payload: token is followed directly by the checksum
    '{xcpd_pkg::REQ_BYTE, 8'h1B, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h7F, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h0E, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h6A, 1'b0, NO_RESULT},
    // size exactly at the limit is a framing error after the low size byte
    '{xcpd_pkg::REQ_BYTE, 8'h1B, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h02, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b1, FRAMING_BIG},
    // wrong token
    '{xcpd_pkg::REQ_BYTE, 8'h1B, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h01, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'hFF, 1'b1, FRAMING_TOKEN},
    // one payload byte, then a timeout while the checksum is awaited
    '{xcpd_pkg::REQ_BYTE, 8'h1B, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h80, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h01, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'h0E, 1'b0, NO_RESULT},
    '{xcpd_pkg::REQ_BYTE, 8'hFF, 1'b1, DATA_FF},
    '{xcpd_pkg::REQ_TICK, 8'hA5, 1'b1, TIMEOUT_SUM}
  };

  // dut signals; the inputs are known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_index;
  logic [1:0]  out_status;
  logic [7:0]  out_seq_number;
  logic [15:0] out_frame_size;

  // frame tracker state, mirrors the deframer
  xcpd_pkg::phase_t trk_phase = xcpd_pkg::PH_IDLE;
  logic [7:0]       trk_seq   = 8'h00;
  logic [15:0]      trk_size  = 16'h0000;
  logic [15:0]      trk_count = 16'h0000;
  logic [7:0]       trk_xor   = 8'h00;

  // results predicted but not yet seen on the out_ channel
  xcpd_pkg::res_t frame_results_q [$];

  int unsigned fail_count     = 0;
  int unsigned counted_items  = 0;
  int unsigned results_seen   = 0;
  int unsigned data_seen      = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned stall_cycles   = 0;
  int unsigned burst_left     = 0;
  bit          big_frame_sent = 1'b0;

  xor_checked_packet_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_status       (out_status),
    .out_seq_number   (out_seq_number),
    .out_frame_size   (out_frame_size)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // status item closing the current frame; the tracker falls back to idle
  function automatic xcpd_pkg::res_t frame_status(input xcpd_pkg::status_t code);
    xcpd_pkg::res_t r;
    r.kind         = xcpd_pkg::KIND_STATUS;
    r.payload_byte = 8'h00;
    r.byte_index   = trk_count;
    r.status       = code;
    r.seq_number   = trk_seq;
    r.frame_size   = trk_size;
    trk_phase      = xcpd_pkg::PH_IDLE;
    return r;
  endfunction

  // advance the frame tracker by one accepted transfer
  task automatic track_frame(input logic req, input logic [7:0] b,
                             output bit produced, output xcpd_pkg::res_t r);
    produced = 1'b0;
    r        = '0;
    if (req == xcpd_pkg::REQ_TICK) begin
      // ticks only matter while a frame is open, checksum stage included
      if (trk_phase != xcpd_pkg::PH_IDLE) begin
        r        = frame_status(xcpd_pkg::ST_TIMEOUT);
        produced = 1'b1;
      end
    end else begin
      case (trk_phase)
        xcpd_pkg::PH_IDLE: begin
          // any byte starts an attempt, header registers cleared first
          trk_seq   = 8'h00;
          trk_size  = 16'h0000;
          trk_count = 16'h0000;
          if (b != xcpd_pkg::START_BYTE) begin
            r        = frame_status(xcpd_pkg::ST_FRAMING);
            produced = 1'b1;
          end else begin
            trk_xor   = xcpd_pkg::START_BYTE;
            trk_phase = xcpd_pkg::PH_SEQ;
          end
        end
        xcpd_pkg::PH_SEQ: begin
          trk_seq   = b;
          trk_xor   ^= b;
          trk_phase = xcpd_pkg::PH_SIZE_HI;
        end
        xcpd_pkg::PH_SIZE_HI: begin
          trk_size  = {b, 8'h00};
          trk_xor   ^= b;
          trk_phase = xcpd_pkg::PH_SIZE_LO;
        end
        xcpd_pkg::PH_SIZE_LO: begin
          trk_size  = trk_size | {8'h00, b};
          trk_xor   ^= b;
          trk_count = 16'h0000;
          if (32'(trk_size) >= 32'(MAX_PAYLOAD)) begin
            r        = frame_status(xcpd_pkg::ST_FRAMING);
            produced = 1'b1;
          end else begin
            trk_phase = xcpd_pkg::PH_TOKEN;
          end
        end
        xcpd_pkg::PH_TOKEN: begin
          if (b != xcpd_pkg::TOKEN_BYTE) begin
            r        = frame_status(xcpd_pkg::ST_FRAMING);
            produced = 1'b1;
          end else begin
            trk_xor   ^= b;
            trk_phase = (trk_size == 16'h0000) ? xcpd_pkg::PH_CHECK : xcpd_pkg::PH_DATA;
          end
        end
        xcpd_pkg::PH_DATA: begin
          r.kind         = xcpd_pkg::KIND_DATA;
          r.payload_byte = b;
          r.byte_index   = trk_count;
          r.status       = xcpd_pkg::ST_OK;
          r.seq_number   = trk_seq;
          r.frame_size   = trk_size;
          produced       = 1'b1;
          trk_xor        ^= b;
          trk_count      = trk_count + 16'd1;
          if (trk_count == trk_size) trk_phase = xcpd_pkg::PH_CHECK;
        end
        xcpd_pkg::PH_CHECK: begin
          r        = frame_status((trk_xor == b) ? xcpd_pkg::ST_OK : xcpd_pkg::ST_BAD_SUM);
          produced = 1'b1;
        end
        default: begin
          trk_phase = xcpd_pkg::PH_IDLE;
        end
      endcase
    end
  endtask

  // offer one transfer and wait for it to be taken; the sender works in
  // bursts, and a gap is only opened at the start of a new burst
  task automatic send_item(input logic req, input logic [7:0] data,
                           input bit typed = 1'b0, input xcpd_pkg::res_t typed_res = '0);
    int unsigned    gap_len;
    bit             produced;
    xcpd_pkg::res_t predicted;
    if (burst_left == 0) begin
      // a quarter of the bursts follow on without a gap
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= data;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // transfer taken at this edge
    if (!(req == xcpd_pkg::REQ_TICK && trk_phase == xcpd_pkg::PH_IDLE)) counted_items++;
    track_frame(req, data, produced, predicted);
    if (produced) frame_results_q.push_back(typed ? typed_res : predicted);
  endtask

  // one random episode starting from idle: mostly well-formed frames with
  // random content, the rest noise, idle ticks, broken headers, bad checksums and timeouts
  task automatic send_episode();
    logic [7:0]  bytes_q [$];
    logic [7:0]  seq_b;
    logic [7:0]  tok;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] size;
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      // dropped tick, random byte field anyway
      send_item(xcpd_pkg::REQ_TICK, 8'($urandom));
    end else if (pick < 12) begin
      // stray byte that is not a start byte
      b = 8'($urandom);
      if (b == xcpd_pkg::START_BYTE) b = ~b;
      send_item(xcpd_pkg::REQ_BYTE, b);
    end else begin
      seq_b = 8'($urandom);
      // 12..19 oversized, 20..25 bad token, 26..33 cut by a timeout,
      // 34..43 bad checksum, the rest clean frames
      if (pick < 20) begin
        size = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                           : 16'($urandom_range(MAX_PAYLOAD, 65535));
      end else if (pick >= 26 && !big_frame_sent && counted_items >= 600) begin
        // one frame of the largest legal size
        size           = 16'(MAX_PAYLOAD - 1);
        big_frame_sent = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        size = 16'($urandom_range(7, 40));
      end else begin
        size = 16'($urandom_range(0, 6));
      end
      bytes_q = '{xcpd_pkg::START_BYTE, seq_b, size[15:8], size[7:0]};
      if (pick >= 20) begin
        tok = xcpd_pkg::TOKEN_BYTE;
        if (pick < 26) begin
          tok = 8'($urandom);
          if (tok == xcpd_pkg::TOKEN_BYTE) tok = ~tok;
        end
        bytes_q.push_back(tok);
        if (pick >= 26) begin
          repeat (size) bytes_q.push_back(8'($urandom));
          sum = 8'h00;
          foreach (bytes_q[i]) sum ^= bytes_q[i];
          if (pick >= 34 && pick < 44) sum ^= 8'($urandom_range(1, 255));
          bytes_q.push_back(sum);
        end
      end
      cut = bytes_q.size();
      // timeout anywhere after the start byte, up to the checksum slot
      if (pick >= 26 && pick < 34) cut = $urandom_range(1, bytes_q.size() - 1);
      for (int i = 0; i < cut; i++) send_item(xcpd_pkg::REQ_BYTE, bytes_q[i]);
      if (cut < bytes_q.size()) send_item(xcpd_pkg::REQ_TICK, 8'($urandom));
    end
  endtask

  // compare one field of a result, report with time and both values
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
    end
  endtask

  // result channel: every transfer is matched against the oldest prediction
  always @(posedge clk) begin
    xcpd_pkg::res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (out_kind == xcpd_pkg::KIND_DATA) data_seen++;
      else status_seen[out_status]++;
      if (frame_results_q.size() == 0) begin
        fail_count++;
        $display({"%0t ns: result with nothing expected, expected none, ",
                  "actual kind %0d status %0d"}, $time, out_kind, out_status);
      end else begin
        want = frame_results_q.pop_front();
        check_field("kind",         16'(want.kind),         16'(out_kind));
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        check_field("byte_index",   want.byte_index,        out_byte_index);
        check_field("status",       16'(want.status),       16'(out_status));
        check_field("seq_number",   16'(want.seq_number),   16'(out_seq_number));
        check_field("frame_size",   want.frame_size,        out_frame_size);
      end
    end
  end

  // receiver: stall patterns picked at random in turn, plus one
  // long hold-off once traffic is flowing so the output stage fills and
  // in_ready has to drop while the sender keeps offering
  initial begin : receiver
    ready_mode_t mode;
    int unsigned mode_left;
    bit          held;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER_RESULTS) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
        RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        RDY_TOGGLE: out_ready <= ~out_ready;
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  // watchdog: too long without a transfer on either channel ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, frame_results_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // main sequence: reset, directed rows, random episodes, drain
  initial begin : stimulus
    int unsigned random_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].want);

    random_start = counted_items;
    while (counted_items - random_start < RANDOM_ITEMS) send_episode();
    in_valid <= 1'b0;

    // wait for every prediction to be matched, then a short quiet tail
    // to catch anything the block still emits
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transfers (dropped idle ticks excluded), %0d payload bytes out%s",
             counted_items, data_seen, big_frame_sent ? ", one largest-size frame" : "");
    $display("frame endings seen: ok %0d, bad checksum %0d, framing %0d, timeout %0d",
             status_seen[xcpd_pkg::ST_OK], status_seen[xcpd_pkg::ST_BAD_SUM],
             status_seen[xcpd_pkg::ST_FRAMING], status_seen[xcpd_pkg::ST_TIMEOUT]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
src/xcpd_pkg.sv
src/xcpd_core.sv
src/xcpd_out_stage.sv
src/xor_checked_packet_deframer.sv
verif/tb_top.sv
